// File: rtl/gtg_pkg.sv
// shared types, constants and the arctangent table of the go-to-goal core
`default_nettype none
package gtg_pkg;

	// configuration registers as seen by the datapath
	typedef struct packed {
		logic [15:0] target_x;
		logic [15:0] target_y;
		logic [11:0] gain;
		logic [15:0] max_speed;
	} cfg_t;

	// register indexes on the configuration port
	typedef enum logic [1:0] {
		REG_TARGET_X  = 2'd0,
		REG_TARGET_Y  = 2'd1,
		REG_GAIN      = 2'd2,
		REG_MAX_SPEED = 2'd3
	} reg_idx_t;

	localparam int unsigned CORDIC_STEPS = 16;
	localparam int unsigned ROOT_BITS    = 17;
	localparam logic signed [19:0] PI_Q16 = 20'sd205887;
	localparam logic [16:0] NEAR_LIMIT = 17'd4;
	localparam logic [16:0] TURN_LIMIT = 17'd820;

	// atan(2^-i) in Q3.16, rounded to nearest
	function automatic logic signed [19:0] atan_q16(input logic [3:0] i);
		logic signed [19:0] a;
		case (i)
			4'd0:    a = 20'sd51472;
			4'd1:    a = 20'sd30386;
			4'd2:    a = 20'sd16055;
			4'd3:    a = 20'sd8150;
			4'd4:    a = 20'sd4091;
			4'd5:    a = 20'sd2047;
			4'd6:    a = 20'sd1024;
			4'd7:    a = 20'sd512;
			4'd8:    a = 20'sd256;
			4'd9:    a = 20'sd128;
			4'd10:   a = 20'sd64;
			4'd11:   a = 20'sd32;
			4'd12:   a = 20'sd16;
			4'd13:   a = 20'sd8;
			4'd14:   a = 20'sd4;
			default: a = 20'sd2;
		endcase
		return a;
	endfunction

endpackage
`default_nettype wire

// File: rtl/gtg_cfg.sv
// configuration register file behind the apb-style port
`default_nettype none
module gtg_cfg
	import gtg_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [3:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic      [31:0] prdata,
	output logic             pready,
	output cfg_t             cfg
);
	cfg_t     cfg_q;
	reg_idx_t idx;

	assign idx    = reg_idx_t'(paddr[3:2]);
	assign pready = 1'b1;
	assign cfg    = cfg_q;

	// register writes on the access phase
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.target_x  <= 16'd4096;
			cfg_q.target_y  <= 16'd4096;
			cfg_q.gain      <= 12'd256;
			cfg_q.max_speed <= 16'd12288;
		end else if (psel && penable && pwrite) begin
			unique case (idx)
				REG_TARGET_X:  cfg_q.target_x  <= pwdata[15:0];
				REG_TARGET_Y:  cfg_q.target_y  <= pwdata[15:0];
				REG_GAIN:      cfg_q.gain      <= pwdata[11:0];
				REG_MAX_SPEED: cfg_q.max_speed <= pwdata[15:0];
				default: ;
			endcase
		end
	end

	// read back
	always_comb begin
		unique case (idx)
			REG_TARGET_X:  prdata = {16'd0, cfg_q.target_x};
			REG_TARGET_Y:  prdata = {16'd0, cfg_q.target_y};
			REG_GAIN:      prdata = {20'd0, cfg_q.gain};
			REG_MAX_SPEED: prdata = {16'd0, cfg_q.max_speed};
			default:       prdata = 32'd0;
		endcase
	end
endmodule
`default_nettype wire

// File: rtl/gtg_iter.sv
// lock-step pipeline of square-root digit stages and vectoring cordic stages
`default_nettype none
module gtg_iter
	import gtg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               en,
	input  wire logic               in_valid,
	input  wire logic [33:0]        in_sum,
	input  wire logic signed [31:0] in_x,
	input  wire logic signed [31:0] in_y,
	input  wire logic signed [19:0] in_z,
	input  wire logic signed [14:0] in_hd,
	output logic                    out_valid,
	output logic [16:0]             out_dist,
	output logic signed [19:0]      out_z,
	output logic signed [14:0]      out_hd
);
	localparam int unsigned N = ROOT_BITS;

	logic               v_sn    [0:N-1];
	logic [33:0]        n_sn    [0:N-1];
	logic [19:0]        rem_sn  [0:N-1];
	logic [16:0]        root_sn [0:N-1];
	logic signed [31:0] x_sn    [0:N-1];
	logic signed [31:0] y_sn    [0:N-1];
	logic signed [19:0] z_sn    [0:N-1];
	logic signed [14:0] hd_sn   [0:N-1];

	genvar k;
	generate
		for (k = 0; k < N; k++) begin : g_stage
			logic               v_p;
			logic [33:0]        n_p;
			logic [19:0]        rem_p;
			logic [16:0]        root_p;
			logic signed [31:0] x_p;
			logic signed [31:0] y_p;
			logic signed [19:0] z_p;
			logic signed [14:0] hd_p;
			logic [19:0]        rem_sh;
			logic [19:0]        trial;
			logic               ge;
			logic signed [31:0] x_n;
			logic signed [31:0] y_n;
			logic signed [19:0] z_n;

			if (k == 0) begin : g_first
				assign v_p    = in_valid;
				assign n_p    = in_sum;
				assign rem_p  = 20'd0;
				assign root_p = 17'd0;
				assign x_p    = in_x;
				assign y_p    = in_y;
				assign z_p    = in_z;
				assign hd_p   = in_hd;
			end else begin : g_next
				assign v_p    = v_sn[k-1];
				assign n_p    = n_sn[k-1];
				assign rem_p  = rem_sn[k-1];
				assign root_p = root_sn[k-1];
				assign x_p    = x_sn[k-1];
				assign y_p    = y_sn[k-1];
				assign z_p    = z_sn[k-1];
				assign hd_p   = hd_sn[k-1];
			end

			// one root digit, most significant pair of the radicand first
			assign rem_sh = {rem_p[17:0], n_p[2*(N-1-k)+1 -: 2]};
			assign trial  = {1'b0, root_p, 2'b01};
			assign ge     = (rem_sh >= trial);

			// one cordic rotation towards the x axis
			if (k < CORDIC_STEPS) begin : g_rot
				always_comb begin
					if (y_p >= 0) begin
						x_n = x_p + (y_p >>> k);
						y_n = y_p - (x_p >>> k);
						z_n = z_p + atan_q16(4'(k));
					end else begin
						x_n = x_p - (y_p >>> k);
						y_n = y_p + (x_p >>> k);
						z_n = z_p - atan_q16(4'(k));
					end
				end
			end else begin : g_pass
				assign x_n = x_p;
				assign y_n = y_p;
				assign z_n = z_p;
			end

			// stage valid
			always_ff @(posedge clk or negedge arst_n) begin
				if (!arst_n) begin
					v_sn[k] <= 1'b0;
				end else if (en) begin
					v_sn[k] <= v_p;
				end
			end

			// stage payload
			always_ff @(posedge clk) begin
				if (en) begin
					n_sn[k]    <= n_p;
					rem_sn[k]  <= ge ? (rem_sh - trial) : rem_sh;
					root_sn[k] <= {root_p[15:0], ge};
					x_sn[k]    <= x_n;
					y_sn[k]    <= y_n;
					z_sn[k]    <= z_n;
					hd_sn[k]   <= hd_p;
				end
			end
		end
	endgenerate

	assign out_valid = v_sn[N-1];
	assign out_dist  = root_sn[N-1];
	assign out_z     = z_sn[N-1];
	assign out_hd    = hd_sn[N-1];
endmodule
`default_nettype wire

// File: rtl/go_to_goal_velocity_law_core.sv
// top level of the proportional go-to-goal velocity law
`default_nettype none
// Takes one pose (pos_x, pos_y, heading) per cycle and returns one velocity
// command per pose, in order. It has 17 square-root digit stages for the
// distance, run side by side with the 16 cordic stages for the bearing,
// plus offset, square, sum, error and output stages. A stall on the result
// channel freezes the pipeline and is passed back to the pose channel.
// Near the goal (distance of four lsb or less) both outputs are zero; with
// a heading error of 820 lsb or more only the unsigned turn rate is given,
// else gain times distance over 256, capped at max_speed. Targets,
// gain and ceiling are at apb byte addresses 0, 4, 8 and 12; the user must
// write them only while no pose is in flight; the block does not enforce it.
module go_to_goal_velocity_law_core
	import gtg_pkg::*;
(
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               psel,
	input  wire logic               penable,
	input  wire logic               pwrite,
	input  wire logic [3:0]         paddr,
	input  wire logic [31:0]        pwdata,
	output logic      [31:0]        prdata,
	output logic                    pready,
	input  wire logic               in_valid,
	output logic                    in_stall,
	input  wire logic [15:0]        pos_x,
	input  wire logic [15:0]        pos_y,
	input  wire logic signed [14:0] heading,
	output logic                    out_valid,
	input  wire logic               out_stall,
	output logic [15:0]             linear_speed,
	output logic [14:0]             turn_rate
);
	cfg_t cfg;
	logic en;

	gtg_cfg u_cfg (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// the pipeline moves unless a finished item is held at the output
	assign en       = !(out_valid && out_stall);
	assign in_stall = out_valid && out_stall;

	logic               v_s1, v_s2, v_s3, v_s21;
	logic signed [16:0] dx_s1, dy_s1;
	logic signed [14:0] hd_s1, hd_s2, hd_s3;
	logic [33:0]        dxsq_s2, dysq_s2, sum_s3;
	logic signed [31:0] x_s2, y_s2, x_s3, y_s3;
	logic signed [19:0] z_s2, z_s3;

	logic               iv;
	logic [16:0]        idist;
	logic signed [19:0] iz;
	logic signed [14:0] ihd;

	logic               near_s21;
	logic [16:0]        mag_s21;
	logic [28:0]        prod_s21;

	logic signed [31:0] x0, y0;
	logic signed [15:0] bearing;
	logic signed [16:0] err;
	logic [20:0]        speed;

	// valid bits of the front and back stages
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			v_s3      <= 1'b0;
			v_s21     <= 1'b0;
			out_valid <= 1'b0;
		end else if (en) begin
			v_s1      <= in_valid;
			v_s2      <= v_s1;
			v_s3      <= v_s2;
			v_s21     <= iv;
			out_valid <= v_s21;
		end
	end

	// offset scaled for the cordic
	assign x0 = 32'(dx_s1) <<< 12;
	assign y0 = 32'(dy_s1) <<< 12;

	// front stages: offset, squares with half-plane fold, sum of squares
	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1   <= $signed({1'b0, cfg.target_x}) - $signed({1'b0, pos_x});
			dy_s1   <= $signed({1'b0, cfg.target_y}) - $signed({1'b0, pos_y});
			hd_s1   <= heading;
			dxsq_s2 <= unsigned'(34'(dx_s1) * 34'(dx_s1));
			dysq_s2 <= unsigned'(34'(dy_s1) * 34'(dy_s1));
			if (dx_s1 < 0) begin
				x_s2 <= -x0;
				y_s2 <= -y0;
				z_s2 <= (dy_s1 >= 0) ? PI_Q16 : -PI_Q16;
			end else begin
				x_s2 <= x0;
				y_s2 <= y0;
				z_s2 <= 20'sd0;
			end
			hd_s2  <= hd_s1;
			sum_s3 <= dxsq_s2 + dysq_s2;
			x_s3   <= x_s2;
			y_s3   <= y_s2;
			z_s3   <= z_s2;
			hd_s3  <= hd_s2;
		end
	end

	gtg_iter u_iter (
		.clk       (clk),
		.arst_n    (arst_n),
		.en        (en),
		.in_valid  (v_s3),
		.in_sum    (sum_s3),
		.in_x      (x_s3),
		.in_y      (y_s3),
		.in_z      (z_s3),
		.in_hd     (hd_s3),
		.out_valid (iv),
		.out_dist  (idist),
		.out_z     (iz),
		.out_hd    (ihd)
	);

	// bearing rounded to q3.12 and heading error
	assign bearing = 16'((iz + 20'sd8) >>> 4);
	assign err     = 17'(bearing) - 17'(ihd);
	assign speed   = prod_s21[28:8];

	// error magnitude and proportional product
	always_ff @(posedge clk) begin
		if (en) begin
			near_s21 <= (idist <= NEAR_LIMIT);
			mag_s21  <= (err < 0) ? 17'(-err) : 17'(err);
			prod_s21 <= 29'(cfg.gain) * 29'(idist);
		end
	end

	// command selection and speed ceiling
	always_ff @(posedge clk) begin
		if (en) begin
			if (near_s21) begin
				linear_speed <= 16'd0;
				turn_rate    <= 15'd0;
			end else if (mag_s21 >= TURN_LIMIT) begin
				linear_speed <= 16'd0;
				turn_rate    <= mag_s21[14:0];
			end else begin
				linear_speed <= (speed > 21'(cfg.max_speed)) ? cfg.max_speed : speed[15:0];
				turn_rate    <= 15'd0;
			end
		end
	end
endmodule
`default_nettype wire
